FILE: hdl/cmft_pkg.sv
`timescale 1ns / 1ps
package cmft_pkg;

  localparam int NUM_CALLS      = 512;
  localparam int SLOTS_PER_CALL = 8;
  localparam int ID_BITS        = 22;

  localparam int CALL_AW = (NUM_CALLS > 1) ? $clog2(NUM_CALLS) : 1;
  localparam int SLOT_AW = (SLOTS_PER_CALL > 1) ? $clog2(SLOTS_PER_CALL) : 1;
  localparam int SIZE_W  = $clog2(SLOTS_PER_CALL + 1);
  localparam int SLOT_DEPTH = NUM_CALLS * (1 << SLOT_AW);

  typedef enum logic [2:0] {
    OP_INTERCEPT = 3'd0,
    OP_RELEASE   = 3'd1,
    OP_START     = 3'd2,
    OP_STOP      = 3'd3,
    OP_EXIT      = 3'd4,
    OP_EVENT     = 3'd5
  } op_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_PERM     = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_NOROOM   = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_LIST = 2'd1;
  localparam logic [1:0] MODE_ALL  = 2'd2;

  localparam logic CFG_RES_A = 1'b0;
  localparam logic CFG_RES_B = 1'b1;

  typedef struct packed {
    logic              intc;
    logic [1:0]        mode;
    logic [SIZE_W-1:0] size;
  } meta_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic meta_rd;
    logic meta_ld;
    logic scan_rd;
    logic scan_cmp;
    logic decide;
    logic last_rd;
    logic last_wr;
    logic next_call;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_scan;
    logic match;
    logic scan_last;
    logic need_remove;
    logic last_call;
    logic is_exit;
    logic out_busy;
  } stat_t;

endpackage

FILE: hdl/cmft_ctrl.sv
`timescale 1ns / 1ps
module cmft_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  cmft_pkg::stat_t st,
  output cmft_pkg::cmd_t  cmd
);
  import cmft_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_META_RD  = 11'b00000000100,
    S_META_LD  = 11'b00000001000,
    S_SCAN_RD  = 11'b00000010000,
    S_SCAN_CMP = 11'b00000100000,
    S_DECIDE   = 11'b00001000000,
    S_LAST_RD  = 11'b00010000000,
    S_LAST_WR  = 11'b00100000000,
    S_NEXT     = 11'b01000000000,
    S_FINISH   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_META_RD;
        end
      end
      S_META_RD: begin
        cmd.meta_rd = 1'b1;
        state_next = S_META_LD;
      end
      S_META_LD: begin
        cmd.meta_ld = 1'b1;
        state_next = st.need_scan ? S_SCAN_RD : S_DECIDE;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_next = (st.match || st.scan_last) ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (st.need_remove) state_next = S_LAST_RD;
        else                state_next = st.is_exit ? S_NEXT : S_FINISH;
      end
      S_LAST_RD: begin
        cmd.last_rd = 1'b1;
        state_next = S_LAST_WR;
      end
      S_LAST_WR: begin
        cmd.last_wr = 1'b1;
        state_next = st.is_exit ? S_NEXT : S_FINISH;
      end
      S_NEXT: begin
        if (st.last_call) begin
          state_next = S_FINISH;
        end else begin
          cmd.next_call = 1'b1;
          state_next = S_META_RD;
        end
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

FILE: hdl/cmft_dp.sv
`timescale 1ns / 1ps
module cmft_dp (
  input  logic            clk,
  input  logic            rst,
  input  cmft_pkg::cmd_t  cmd,
  output cmft_pkg::stat_t st,
  input  logic [39:0]     s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [9:0]      cfg_data
);
  import cmft_pkg::*;

  // config
  logic [9:0] res_a, res_b;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      res_a <= 10'd0;
      res_b <= 10'd252;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RES_A: res_a <= cfg_data;
        CFG_RES_B: res_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched request
  logic [2:0]  op;
  logic [10:0] craw;
  logic [22:0] praw;
  logic        root, exists, owner;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op     <= s_tdata[2:0];
      craw   <= s_tdata[13:3];
      praw   <= s_tdata[36:14];
      root   <= s_tdata[37];
      exists <= s_tdata[38];
      owner  <= s_tdata[39];
    end
  end

  function automatic logic in_range(input logic [10:0] c);
    return !c[10] && ({22'd0, c[9:0]} < 32'(NUM_CALLS));
  endfunction

  logic [21:0] id;
  logic        id_ok, c_ok, c_bad, is_exit;
  assign id      = praw[21:0];
  assign id_ok   = !praw[22] && ((64'(id) >> ID_BITS) == 64'd0);
  assign c_ok    = in_range(craw);
  assign c_bad   = !c_ok || (craw == {1'b0, res_a}) || (craw == {1'b0, res_b});
  assign is_exit = (op == OP_EXIT);

  // call pointer, also the clearing counter
  logic [CALL_AW-1:0] cur_call;
  logic [10:0]        in_c;
  assign in_c = s_tdata[13:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_call <= '0;
    end else if (cmd.clr_wr || cmd.next_call) begin
      cur_call <= cur_call + 1'b1;
    end else if (cmd.accept) begin
      if (s_tdata[2:0] == OP_EXIT || !in_range(in_c)) cur_call <= '0;
      else cur_call <= in_c[CALL_AW-1:0];
    end
  end

  // memories
  meta_t              meta_mem [NUM_CALLS];
  logic [21:0]        slot_mem [SLOT_DEPTH];
  meta_t              meta_rd, meta_q, meta_new;
  logic [21:0]        slot_rd;
  logic [SIZE_W-1:0]  idx;
  logic [SLOT_AW-1:0] k;
  logic               found, hit;
  logic               meta_we, app_we, rem;
  logic [2:0]         status_v;
  logic               log_v;
  logic [SIZE_W-1:0]  size_m1;

  assign size_m1 = meta_q.size - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) meta_mem[cur_call] <= '0;
    else if (cmd.decide && meta_we) meta_mem[cur_call] <= meta_new;
    if (cmd.meta_rd) meta_rd <= meta_mem[cur_call];
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && app_we)
      slot_mem[{cur_call, meta_q.size[SLOT_AW-1:0]}] <= id;
    else if (cmd.last_wr)
      slot_mem[{cur_call, k}] <= slot_rd;
    if (cmd.scan_rd)      slot_rd <= slot_mem[{cur_call, idx[SLOT_AW-1:0]}];
    else if (cmd.last_rd) slot_rd <= slot_mem[{cur_call, size_m1[SLOT_AW-1:0]}];
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.meta_ld) begin
      meta_q <= meta_rd;
      idx    <= '0;
      found  <= 1'b0;
    end else if (cmd.scan_cmp) begin
      if (st.match) begin
        found <= 1'b1;
        k     <= idx[SLOT_AW-1:0];
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) hit <= 1'b0;
    else if (cmd.decide && is_exit && found) hit <= 1'b1;
  end

  // per-op decision
  always_comb begin
    logic [2:0] mc;
    meta_t      removed;
    mc = ST_OK;
    if (!meta_q.intc)     mc = ST_INVALID;
    else if (!id_ok)      mc = ST_INVALID;
    else if (!root) begin
      if (id == 22'd0)    mc = ST_PERM;
      else if (!exists)   mc = ST_INVALID;
      else if (!owner)    mc = ST_PERM;
    end
    removed = meta_q;
    removed.size = size_m1;
    if (size_m1 == '0 && meta_q.mode == MODE_LIST) removed.mode = MODE_OFF;

    status_v = ST_OK;
    log_v    = 1'b0;
    meta_new = meta_q;
    meta_we  = 1'b0;
    app_we   = 1'b0;
    rem      = 1'b0;

    if (is_exit) begin
      status_v = ST_OK;
      if (found) begin
        meta_new = removed;
        meta_we  = 1'b1;
        rem      = 1'b1;
      end
    end else if (op == OP_EVENT) begin
      if (!c_ok) status_v = ST_INVALID;
      else log_v = (meta_q.mode == MODE_ALL) || (meta_q.mode == MODE_LIST && found);
    end else if (c_bad) begin
      status_v = ST_INVALID;
    end else begin
      case (op)
        OP_INTERCEPT: begin
          if (!root)            status_v = ST_PERM;
          else if (meta_q.intc) status_v = ST_BUSY;
          else begin
            meta_new.intc = 1'b1;
            meta_we = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (!root)             status_v = ST_PERM;
          else if (!meta_q.intc) status_v = ST_INVALID;
          else begin
            meta_new = '0;
            meta_we  = 1'b1;
          end
        end
        OP_START: begin
          status_v = mc;
          if (status_v == ST_OK) begin
            if (meta_q.mode == MODE_ALL) status_v = ST_BUSY;
            else if (meta_q.mode == MODE_LIST && id != 22'd0 && found) status_v = ST_BUSY;
          end
          if (status_v == ST_OK) begin
            if (id == 22'd0) begin
              meta_new.size = '0;
              meta_new.mode = MODE_ALL;
              meta_we = 1'b1;
            end else if ({{(32-SIZE_W){1'b0}}, meta_q.size} >= 32'(SLOTS_PER_CALL)) begin
              status_v = ST_NOROOM;
            end else begin
              meta_new.size = meta_q.size + 1'b1;
              if (meta_q.mode == MODE_OFF) meta_new.mode = MODE_LIST;
              meta_we = 1'b1;
              app_we  = 1'b1;
            end
          end
        end
        OP_STOP: begin
          status_v = mc;
          if (status_v == ST_OK) begin
            if (meta_q.mode == MODE_ALL) begin
              if (id != 22'd0) status_v = ST_INVALID;
            end else if (meta_q.mode != MODE_LIST) begin
              status_v = ST_INVALID;
            end else if (id != 22'd0 && !found) begin
              status_v = ST_INVALID;
            end
          end
          if (status_v == ST_OK) begin
            meta_we = 1'b1;
            if (id == 22'd0) begin
              meta_new.size = '0;
              meta_new.mode = MODE_OFF;
            end else begin
              meta_new = removed;
              rem = 1'b1;
            end
          end
        end
        default: status_v = ST_INVALID;
      endcase
    end
  end

  // result register
  logic [2:0] out_status;
  logic       out_log;
  logic [2:0] fin_status;
  logic       fin_log;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      fin_status <= status_v;
      fin_log    <= log_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= is_exit ? (hit ? ST_OK : ST_NOTFOUND) : fin_status;
      out_log    <= is_exit ? 1'b0 : fin_log;
    end
  end

  assign m_tdata = {4'd0, out_log, out_status};

  assign st.clr_done    = ({{(32-CALL_AW){1'b0}}, cur_call} == 32'(NUM_CALLS - 1));
  assign st.last_call   = st.clr_done;
  assign st.need_scan   = meta_rd.size != '0 && (op == OP_START || op == OP_STOP ||
                          op == OP_EXIT || op == OP_EVENT);
  assign st.match       = id_ok && (slot_rd == id);
  assign st.scan_last   = (SIZE_W'(idx + 1'b1) == meta_q.size);
  assign st.need_remove = rem;
  assign st.is_exit     = is_exit;
  assign st.out_busy    = m_tvalid && !m_tready;

endmodule

FILE: hdl/call_monitor_filter_table_top.sv
`timescale 1ns / 1ps
// Call monitor filter table: keeps per call number an intercepted flag, a monitor
// mode and up to SLOTS_PER_CALL monitored process ids, and answers intercept,
// release, start/stop monitor, process exit and call event requests with one
// status transaction each. One request is in work at a time. After reset a
// clearing pass over all NUM_CALLS (512) entries sweeps the per-call table before
// the first request is taken. A request reads its call's metadata, scans the ids
// in that call's set one by one up to a match where the op needs it (the slot
// memory has one read port), decides and, for a removal, moves the last id into
// the freed slot; a process exit repeats this for every call number. Config
// writes are accepted any time.
module call_monitor_filter_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[2:0], call_number[13:3], process_id[36:14], caller_is_root[37],
  // target_exists[38], same_owner[39]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], log_event[3], zero[7:4]
  output logic [7:0]  m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);
  import cmft_pkg::*;

  cmd_t  cmd;
  stat_t st;

  cmft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  cmft_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: hdl/cmft_checker.sv
`timescale 1ns / 1ps
module cmft_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_index,
  input logic [9:0]  cfg_data
);
  import cmft_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // clearing pass blocks requests right after reset
  a_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request taken during clearing pass");

  // one request in work at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // log only with ok status
  a_log: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[2:0] == ST_OK)
    else $error("log flag with error status");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_NOTFOUND && m_tdata[7:4] == 4'd0)
    else $error("bad status code");

endmodule

bind call_monitor_filter_table_top cmft_checker u_chk (.*);
